// ----- sv/v3a_pkg.sv -----
// Shared types, opcodes and helpers for the three-component vector unit.
// Used by the root pipeline and by the top level vector3_alu.
package v3a_pkg;

   // width of unsaturated intermediate results
   localparam int WIDE_W = 66;

   // steps of the integer square root (64-bit radicand, 32-bit root)
   localparam int SQ_STEPS = 32;

   typedef logic signed [31:0]       q_type;
   typedef logic signed [WIDE_W-1:0] wide_type;

   typedef enum logic [4:0] {
      OP_ADDV       = 5'd0,
      OP_ADDS       = 5'd1,
      OP_SUBV       = 5'd2,
      OP_SUBS       = 5'd3,
      OP_MULV       = 5'd4,
      OP_MULS       = 5'd5,
      OP_DIVV       = 5'd6,
      OP_DIVS       = 5'd7,
      OP_DOT        = 5'd8,
      OP_CROSS      = 5'd9,
      OP_MAG        = 5'd10,
      OP_MAGSQ      = 5'd11,
      OP_DIST       = 5'd12,
      OP_DISTSQ     = 5'd13,
      OP_NORM       = 5'd14,
      OP_NORMSAFE   = 5'd15,
      OP_SETMAG     = 5'd16,
      OP_SETMAGSAFE = 5'd17,
      OP_LIMITS     = 5'd18,
      OP_LIMITV     = 5'd19,
      OP_EQUAL      = 5'd20
   } op_type;

   localparam q_type Q_MAX = 32'sh7fff_ffff;
   localparam q_type Q_MIN = 32'sh8000_0000;

   // request context carried alongside the root pipeline
   typedef struct packed {
      op_type          op;
      q_type [2:0]     a;
      q_type [2:0]     b;
      q_type           s;
      wide_type [2:0]  r;
      q_type           sc;
      logic            sc_ov;
   } c_side_type;

   // request context carried alongside the divide pipeline
   typedef struct packed {
      op_type          op;
      q_type [2:0]     a;
      wide_type [2:0]  r;
      q_type           sc;
      logic            sc_ov;
      q_type           mult;
      logic            do_div;
      logic            pass_a;
      logic [2:0]      q_neg;
      logic [2:0]      dz;
      q_type [2:0]     dz_val;
   } d_side_type;

   // context after the quotients are saturated
   typedef struct packed {
      op_type          op;
      q_type [2:0]     a;
      wide_type [2:0]  r;
      q_type           sc;
      logic            sc_ov;
      q_type           mult;
      logic            pass_a;
      q_type [2:0]     n;
      logic            ov_q;
      logic            dz_q;
   } e_side_type;

   // saturate to 32 bits: {saturated flag, value}
   function automatic logic [32:0] sat32(input wide_type v);
      logic [32:0] res;
      if (v > wide_type'(Q_MAX)) begin
         res = {1'b1, Q_MAX};
      end else if (v < wide_type'(Q_MIN)) begin
         res = {1'b1, Q_MIN};
      end else begin
         res = {1'b0, v[31:0]};
      end
      return res;
   endfunction

endpackage

// ----- sv/v3a_sqrt.sv -----
// Pipelined floor integer square root, one result bit per stage.
// Depends on v3a_pkg for the step count.
module v3a_sqrt (
   input  logic        clock,
   input  logic        enable,
   input  logic [63:0] rad_in,
   output logic [31:0] root_out
);
   import v3a_pkg::*;

   logic [33:0] rem_ff  [SQ_STEPS-1];
   logic [63:0] rad_ff  [SQ_STEPS-1];
   logic [31:0] root_ff [SQ_STEPS];

   for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
      logic [33:0] rem_prev;
      logic [63:0] rad_prev;
      logic [31:0] root_prev;
      logic [35:0] t_w;
      logic [35:0] trial_w;
      logic        ge_w;
      logic [31:0] root_in;

      if (k == 0) begin : g_first
         assign rem_prev  = '0;
         assign rad_prev  = rad_in;
         assign root_prev = '0;
      end else begin : g_next
         assign rem_prev  = rem_ff[k-1];
         assign rad_prev  = rad_ff[k-1];
         assign root_prev = root_ff[k-1];
      end

      // bring down two radicand bits, try root*4+1
      assign t_w     = {rem_prev, rad_prev[63:62]};
      assign trial_w = {2'b00, root_prev, 2'b01};
      assign ge_w    = (t_w >= trial_w);
      assign root_in = {root_prev[30:0], ge_w};

      always_ff @(posedge clock) begin
         if (enable) begin
            root_ff[k] <= root_in;
         end
      end

      if (k < SQ_STEPS - 1) begin : g_carry
         logic [33:0] rem_in;
         assign rem_in = ge_w ? 34'(t_w - trial_w) : t_w[33:0];
         always_ff @(posedge clock) begin
            if (enable) begin
               rem_ff[k] <= rem_in;
               rad_ff[k] <= {rad_prev[61:0], 2'b00};
            end
         end
      end
   end

   assign root_out = root_ff[SQ_STEPS-1];

endmodule

// ----- sv/v3a_div.sv -----
// Pipelined restoring unsigned divider, one quotient bit per stage.
// Standalone; width of the dividend set by NUM_W.
module v3a_div #(
   parameter int NUM_W = 48
) (
   input  logic             clock,
   input  logic             enable,
   input  logic [NUM_W-1:0] num_in,
   input  logic [32:0]      den_in,
   output logic [NUM_W-1:0] quo_out
);

   logic [32:0]      rem_ff [NUM_W-1];
   logic [32:0]      den_ff [NUM_W-1];
   logic [NUM_W-1:0] nq_ff  [NUM_W];

   for (genvar k = 0; k < NUM_W; k++) begin : g_step
      logic [32:0]      rem_prev;
      logic [32:0]      den_prev;
      logic [NUM_W-1:0] nq_prev;
      logic [33:0]      t_w;
      logic             ge_w;
      logic [NUM_W-1:0] nq_in;

      if (k == 0) begin : g_first
         assign rem_prev = '0;
         assign den_prev = den_in;
         assign nq_prev  = num_in;
      end else begin : g_next
         assign rem_prev = rem_ff[k-1];
         assign den_prev = den_ff[k-1];
         assign nq_prev  = nq_ff[k-1];
      end

      // shift in the next dividend bit, subtract if it fits
      assign t_w   = {rem_prev, nq_prev[NUM_W-1]};
      assign ge_w  = (t_w >= {1'b0, den_prev});
      assign nq_in = {nq_prev[NUM_W-2:0], ge_w};

      always_ff @(posedge clock) begin
         if (enable) begin
            nq_ff[k] <= nq_in;
         end
      end

      if (k < NUM_W - 1) begin : g_carry
         logic [32:0] rem_in;
         assign rem_in = ge_w ? 33'(t_w - {1'b0, den_prev}) : t_w[32:0];
         always_ff @(posedge clock) begin
            if (enable) begin
               rem_ff[k] <= rem_in;
               den_ff[k] <= den_prev;
            end
         end
      end
   end

   assign quo_out = nq_ff[NUM_W-1];

endmodule

// ----- sv/vector3_alu.sv -----
// Fixed-point (Q16.16 by default) three-component vector unit, fully
// pipelined: one request is taken every clock unless the output is held.
// Most of its stages lie in the 32-stage square-root pipeline and in the
// (32 + FRAC_BITS)-stage divider that it feeds, used by divide, normalize,
// set magnitude and limit. The whole pipeline advances together and halts
// only while a result waits on rsp_tready.
// Depends on v3a_pkg, v3a_sqrt and v3a_div.
module vector3_alu #(
   parameter int FRAC_BITS    = 16,
   parameter int SAFE_EPSILON = 7
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [223:0] req_tdata,  // ax, ay, az, bx, by, bz, scalar_in
   input  logic [4:0]   req_tuser,  // req_type
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata,  // rx, ry, rz, scalar_out
   output logic [1:0]   rsp_tuser   // overflow, div_zero
);
   import v3a_pkg::*;

   localparam int NW     = 32 + FRAC_BITS;
   localparam int PIPE_N = 39 + NW;
   localparam logic [31:0] QONE = 32'd1 << FRAC_BITS;

   logic adv;
   logic [PIPE_N-1:0] vld_ff;

   // global advance: everything moves unless the output is held
   assign adv        = !vld_ff[PIPE_N-1] || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = vld_ff[PIPE_N-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[PIPE_N-2:0], req_tvalid};
      end
   end

   // ---------------- stage A: request register
   op_type      a_op_ff;
   q_type [2:0] a_av_ff, a_bv_ff;
   q_type       a_s_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         a_op_ff <= op_type'(req_tuser);
         for (int i = 0; i < 3; i++) begin
            a_av_ff[i] <= req_tdata[32*i +: 32];
            a_bv_ff[i] <= req_tdata[96 + 32*i +: 32];
         end
         a_s_ff <= req_tdata[223:192];
      end
   end

   // ---------------- stage B: products and squares
   op_type             b_op_ff;
   q_type [2:0]        b_av_ff, b_bv_ff;
   q_type              b_s_ff;
   logic               b_eq_ff;
   logic signed [63:0] b_pm_ff  [3];
   logic signed [63:0] b_cp_ff  [6];
   logic [63:0]        b_sqa_ff [3];
   logic [63:0]        b_sqe_ff [3];

   logic signed [32:0] e_w   [3];
   logic signed [65:0] sqe_w [3];
   logic signed [63:0] sqa_w [3];
   q_type              mo_w  [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (a_op_ff == OP_DIST || a_op_ff == OP_DISTSQ) begin
            e_w[i] = $signed({a_av_ff[i][31], a_av_ff[i]})
                   - $signed({a_bv_ff[i][31], a_bv_ff[i]});
         end else begin
            e_w[i] = $signed({a_bv_ff[i][31], a_bv_ff[i]});
         end
         mo_w[i]  = (a_op_ff == OP_MULS) ? a_s_ff : a_bv_ff[i];
         sqa_w[i] = $signed(a_av_ff[i]) * $signed(a_av_ff[i]);
         sqe_w[i] = e_w[i] * e_w[i];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b_op_ff <= a_op_ff;
         b_av_ff <= a_av_ff;
         b_bv_ff <= a_bv_ff;
         b_s_ff  <= a_s_ff;
         b_eq_ff <= (a_av_ff == a_bv_ff);
         for (int i = 0; i < 3; i++) begin
            b_pm_ff[i]  <= $signed(a_av_ff[i]) * $signed(mo_w[i]);
            b_sqa_ff[i] <= sqa_w[i][63:0];
            b_sqe_ff[i] <= sqe_w[i][63:0];
         end
         b_cp_ff[0] <= $signed(a_av_ff[1]) * $signed(a_bv_ff[2]);
         b_cp_ff[1] <= $signed(a_av_ff[2]) * $signed(a_bv_ff[1]);
         b_cp_ff[2] <= $signed(a_av_ff[2]) * $signed(a_bv_ff[0]);
         b_cp_ff[3] <= $signed(a_av_ff[0]) * $signed(a_bv_ff[2]);
         b_cp_ff[4] <= $signed(a_av_ff[0]) * $signed(a_bv_ff[1]);
         b_cp_ff[5] <= $signed(a_av_ff[1]) * $signed(a_bv_ff[0]);
      end
   end

   // ---------------- stage C: sums, direct results, radicands
   c_side_type  c_side_in, c_side_ff;
   logic [63:0] c_sqa_in, c_sqa_ff;
   logic [63:0] c_sqe_in, c_sqe_ff;

   always_comb begin
      logic [65:0]  sqe_full;
      wide_type     dot_w;
      logic [32:0]  st_w;
      sqe_full = {2'b00, b_sqe_ff[0]} + {2'b00, b_sqe_ff[1]} + {2'b00, b_sqe_ff[2]};
      dot_w    = wide_type'(b_pm_ff[0]) + wide_type'(b_pm_ff[1])
               + wide_type'(b_pm_ff[2]);
      c_sqa_in = b_sqa_ff[0] + b_sqa_ff[1] + b_sqa_ff[2];
      // distance squares can pass 64 bits: cap at all ones
      c_sqe_in = (|sqe_full[65:64]) ? '1 : sqe_full[63:0];
      st_w     = '0;

      c_side_in       = '0;
      c_side_in.op    = b_op_ff;
      c_side_in.a     = b_av_ff;
      c_side_in.b     = b_bv_ff;
      c_side_in.s     = b_s_ff;
      for (int i = 0; i < 3; i++) begin
         case (b_op_ff)
            OP_ADDV: c_side_in.r[i] = wide_type'(b_av_ff[i]) + wide_type'(b_bv_ff[i]);
            OP_ADDS: c_side_in.r[i] = wide_type'(b_av_ff[i]) + wide_type'(b_s_ff);
            OP_SUBV: c_side_in.r[i] = wide_type'(b_av_ff[i]) - wide_type'(b_bv_ff[i]);
            OP_SUBS: c_side_in.r[i] = wide_type'(b_av_ff[i]) - wide_type'(b_s_ff);
            OP_MULV, OP_MULS: c_side_in.r[i] = wide_type'(b_pm_ff[i]) >>> FRAC_BITS;
            OP_CROSS: c_side_in.r[i] = (wide_type'(b_cp_ff[2*i])
                                      - wide_type'(b_cp_ff[2*i+1])) >>> FRAC_BITS;
            default: c_side_in.r[i] = '0;
         endcase
      end
      case (b_op_ff)
         OP_DOT:    st_w = sat32(dot_w >>> FRAC_BITS);
         OP_MAGSQ:  st_w = sat32(wide_type'({2'b00, c_sqa_in} >> FRAC_BITS));
         OP_DISTSQ: st_w = sat32(wide_type'({2'b00, c_sqe_in} >> FRAC_BITS));
         OP_EQUAL:  st_w = {1'b0, b_eq_ff ? QONE : 32'd0};
         default:   st_w = '0;
      endcase
      c_side_in.sc    = st_w[31:0];
      c_side_in.sc_ov = st_w[32];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         c_side_ff <= c_side_in;
         c_sqa_ff  <= c_sqa_in;
         c_sqe_ff  <= c_sqe_in;
      end
   end

   // ---------------- square roots of |a|^2 and of |b|^2 or |a-b|^2
   logic [31:0] m_w, mb_w;
   c_side_type  sq_line_ff [SQ_STEPS];

   v3a_sqrt u_sqrt_a (
      .clock    (clock),
      .enable   (adv),
      .rad_in   (c_sqa_ff),
      .root_out (m_w)
   );

   v3a_sqrt u_sqrt_e (
      .clock    (clock),
      .enable   (adv),
      .rad_in   (c_sqe_ff),
      .root_out (mb_w)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_line_ff[0] <= c_side_ff;
         for (int k = 1; k < SQ_STEPS; k++) begin
            sq_line_ff[k] <= sq_line_ff[k-1];
         end
      end
   end

   // ---------------- stage D: limit test, divisor selection
   d_side_type       d_side_in, d_side_ff;
   logic [NW-1:0]    d_num_in [3];
   logic [NW-1:0]    d_num_ff [3];
   logic [32:0]      d_den_in [3];
   logic [32:0]      d_den_ff [3];

   always_comb begin
      c_side_type         sq;
      q_type              lim_w;
      logic               over_w;
      logic signed [33:0] den_s;
      logic [33:0]        den_m;
      logic [31:0]        amag;
      logic [32:0]        mag_eps;
      sq      = sq_line_ff[SQ_STEPS-1];
      mag_eps = {1'b0, m_w} + 33'(SAFE_EPSILON);
      if (sq.op == OP_LIMITV) begin
         lim_w = mb_w[31] ? Q_MAX : q_type'(mb_w);
      end else begin
         lim_w = sq.s;
      end
      over_w = $signed({2'b00, m_w}) > $signed({{2{lim_w[31]}}, lim_w});

      d_side_in       = '0;
      d_side_in.op    = sq.op;
      d_side_in.a     = sq.a;
      d_side_in.r     = sq.r;
      d_side_in.sc    = sq.sc;
      d_side_in.sc_ov = sq.sc_ov;
      // magnitudes returned as scalars
      if (sq.op == OP_MAG) begin
         d_side_in.sc    = m_w[31] ? Q_MAX : q_type'(m_w);
         d_side_in.sc_ov = m_w[31];
      end else if (sq.op == OP_DIST) begin
         d_side_in.sc    = mb_w[31] ? Q_MAX : q_type'(mb_w);
         d_side_in.sc_ov = mb_w[31];
      end
      d_side_in.mult   = (sq.op inside {OP_LIMITS, OP_LIMITV}) ? lim_w : sq.s;
      d_side_in.pass_a = (sq.op inside {OP_LIMITS, OP_LIMITV}) && !over_w;
      d_side_in.do_div = (sq.op inside {OP_DIVV, OP_DIVS, OP_NORM, OP_NORMSAFE,
                                        OP_SETMAG, OP_SETMAGSAFE})
                       || ((sq.op inside {OP_LIMITS, OP_LIMITV}) && over_w);

      for (int i = 0; i < 3; i++) begin
         case (sq.op)
            OP_DIVV:             den_s = 34'(sq.b[i]);
            OP_DIVS:             den_s = 34'(sq.s);
            OP_NORM, OP_SETMAG:  den_s = {2'b00, m_w};
            default:             den_s = {1'b0, mag_eps};
         endcase
         den_m    = den_s[33] ? 34'(-den_s) : den_s;
         amag     = sq.a[i][31] ? 32'(-sq.a[i]) : sq.a[i];
         d_num_in[i] = {amag, {FRAC_BITS{1'b0}}};
         d_den_in[i] = den_m[32:0];
         d_side_in.q_neg[i]  = sq.a[i][31] ^ den_s[33];
         d_side_in.dz[i]     = (den_m == '0);
         if (sq.a[i][31]) begin
            d_side_in.dz_val[i] = Q_MIN;
         end else if (sq.a[i] != '0) begin
            d_side_in.dz_val[i] = Q_MAX;
         end else begin
            d_side_in.dz_val[i] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d_side_ff <= d_side_in;
         d_num_ff  <= d_num_in;
         d_den_ff  <= d_den_in;
      end
   end

   // ---------------- three divider lanes
   logic [NW-1:0] quo_w [3];
   d_side_type    dv_line_ff [NW];

   for (genvar i = 0; i < 3; i++) begin : g_lane
      v3a_div #(.NUM_W(NW)) u_div (
         .clock   (clock),
         .enable  (adv),
         .num_in  (d_num_ff[i]),
         .den_in  (d_den_ff[i]),
         .quo_out (quo_w[i])
      );
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dv_line_ff[0] <= d_side_ff;
         for (int k = 1; k < NW; k++) begin
            dv_line_ff[k] <= dv_line_ff[k-1];
         end
      end
   end

   // ---------------- stage E: sign and saturate quotients
   e_side_type e_side_in, e_side_ff;

   always_comb begin
      d_side_type  dv;
      wide_type    qw;
      logic [32:0] st_w;
      logic        ov_w;
      logic        dz_w;
      dv   = dv_line_ff[NW-1];
      ov_w = 1'b0;
      dz_w = 1'b0;
      e_side_in        = '0;
      e_side_in.op     = dv.op;
      e_side_in.a      = dv.a;
      e_side_in.r      = dv.r;
      e_side_in.sc     = dv.sc;
      e_side_in.sc_ov  = dv.sc_ov;
      e_side_in.mult   = dv.mult;
      e_side_in.pass_a = dv.pass_a;
      for (int i = 0; i < 3; i++) begin
         qw   = wide_type'({{(WIDE_W-NW){1'b0}}, quo_w[i]});
         qw   = dv.q_neg[i] ? -qw : qw;
         st_w = sat32(qw);
         if (dv.dz[i]) begin
            e_side_in.n[i] = dv.dz_val[i];
            dz_w = 1'b1;
         end else begin
            e_side_in.n[i] = st_w[31:0];
            ov_w = ov_w | st_w[32];
         end
      end
      e_side_in.ov_q = dv.do_div & ov_w;
      e_side_in.dz_q = dv.do_div & dz_w;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         e_side_ff <= e_side_in;
      end
   end

   // ---------------- stage F: scale by the target magnitude
   e_side_type         f_side_ff;
   wide_type           f_p_ff [3];
   logic signed [63:0] f_m_w  [3];

   // full 64-bit products of quotient and target
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         f_m_w[i] = $signed(e_side_ff.n[i]) * $signed(e_side_ff.mult);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f_side_ff <= e_side_ff;
         for (int i = 0; i < 3; i++) begin
            f_p_ff[i] <= wide_type'(f_m_w[i]) >>> FRAC_BITS;
         end
      end
   end

   // ---------------- stage G: result select and output register
   q_type [2:0] o_r_ff;
   q_type       o_sc_ff;
   logic        o_ov_ff;
   logic        o_dz_ff;
   op_type      o_op_ff;

   q_type [2:0] o_r_in;
   logic        o_ov_in;

   always_comb begin
      wide_type    pick;
      logic [32:0] st_w;
      o_ov_in = f_side_ff.sc_ov | f_side_ff.ov_q;
      for (int i = 0; i < 3; i++) begin
         case (f_side_ff.op)
            OP_DIVV, OP_DIVS, OP_NORM, OP_NORMSAFE:
               pick = wide_type'(f_side_ff.n[i]);
            OP_SETMAG, OP_SETMAGSAFE:
               pick = f_p_ff[i];
            OP_LIMITS, OP_LIMITV:
               pick = f_side_ff.pass_a ? wide_type'(f_side_ff.a[i]) : f_p_ff[i];
            default:
               pick = f_side_ff.r[i];
         endcase
         st_w      = sat32(pick);
         o_r_in[i] = st_w[31:0];
         o_ov_in   = o_ov_in | st_w[32];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         o_r_ff  <= o_r_in;
         o_sc_ff <= f_side_ff.sc;
         o_ov_ff <= o_ov_in;
         o_dz_ff <= f_side_ff.dz_q;
         o_op_ff <= f_side_ff.op;
      end
   end

   assign rsp_tdata = {o_sc_ff, o_r_ff[2], o_r_ff[1], o_r_ff[0]};
   assign rsp_tuser = {o_dz_ff, o_ov_ff};

   // ---------------- checks
   // scalar operations leave the vector result at zero
   a_scalar_zero_vec : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (o_op_ff == OP_DOT || o_op_ff == OP_MAG || o_op_ff == OP_MAGSQ
                  || o_op_ff == OP_DIST || o_op_ff == OP_DISTSQ
                  || o_op_ff == OP_EQUAL)
      |-> rsp_tdata[95:0] == '0)
      else $error("vector result not zero on a scalar operation");

   // only the unguarded divides can see a zero divisor
   a_div_zero_src : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1]
      |-> (o_op_ff == OP_DIVV || o_op_ff == OP_DIVS || o_op_ff == OP_NORM
           || o_op_ff == OP_SETMAG))
      else $error("div_zero raised by an operation with a safe divisor");

   // equality answers 1.0 or 0 and never saturates
   a_equal_form : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && o_op_ff == OP_EQUAL
      |-> !rsp_tuser[0] && (o_sc_ff == '0 || o_sc_ff == QONE))
      else $error("bad equality result");

endmodule

// ----- dv/vector3_alu_tb.sv -----
// Self-checking testbench for vector3_alu: directed table then random requests.
// Each request is predicted here and compared with the result stream in order.
// Depends on v3a_pkg and the vector3_alu RTL.
module vector3_alu_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import v3a_pkg::*;

   typedef logic signed [127:0] big_type;

   typedef struct packed {
      q_type rx;
      q_type ry;
      q_type rz;
      q_type sc;
      logic  ov;
      logic  dz;
   } vres_type;

   typedef struct {
      logic [4:0]  op;
      q_type [2:0] a;
      q_type [2:0] b;
      q_type       s;
      bit          typed;
      vres_type    want;
   } vrow_type;

   localparam int      FRAC      = 16;
   localparam int      EPS       = 7;
   localparam int      IDLE_LIM  = 3000;
   localparam int      N_RANDOM  = 1700;
   localparam big_type ONE       = big_type'(1) <<< FRAC;
   localparam big_type TOP       = big_type'(Q_MAX);
   localparam big_type BOT       = big_type'(Q_MIN);
   localparam logic [4:0] OP_UNUSED = 5'd21;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [223:0] req_tdata;   // ax, ay, az, bx, by, bz, scalar_in
   logic [4:0]   req_tuser;   // req_type
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [127:0] rsp_tdata;   // rx, ry, rz, scalar_out
   logic [1:0]   rsp_tuser;   // overflow, div_zero

   vres_type expected_q[$];
   int       n_mismatch;
   int       idle_cycles;
   bit       burst;

   vector3_alu u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------- arithmetic helpers ----------------
   function automatic q_type clamp(input big_type v, inout logic ov);
      if (v > TOP) begin
         ov = 1'b1;
         return Q_MAX;
      end
      if (v < BOT) begin
         ov = 1'b1;
         return Q_MIN;
      end
      return q_type'(v[31:0]);
   endfunction

   // floor integer square root of a 64-bit value
   function automatic logic [63:0] root64(input logic [63:0] v);
      logic [63:0] r;
      logic [63:0] bitv;
      r    = '0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= r + bitv) begin
            v = v - (r + bitv);
            r = (r >> 1) + bitv;
         end else begin
            r = r >> 1;
         end
         bitv = bitv >> 2;
      end
      return r;
   endfunction

   // sum of squares, capped at the top of 64 bits
   function automatic logic [63:0] squares(input big_type x, input big_type y,
                                           input big_type z);
      big_type acc;
      acc = (x * x) + (y * y) + (z * z);
      if (acc > $signed({64'd0, 64'hffff_ffff_ffff_ffff})) return 64'hffff_ffff_ffff_ffff;
      return acc[63:0];
   endfunction

   function automatic big_type fmul(input big_type x, input big_type y);
      return (x * y) >>> FRAC;
   endfunction

   function automatic big_type fdiv(input big_type num, input big_type den, inout logic dz);
      if (den == 0) begin
         dz = 1'b1;
         return num > 0 ? TOP : (num < 0 ? BOT : big_type'(0));
      end
      return (num <<< FRAC) / den;
   endfunction

   function automatic big_type widen(input logic [63:0] u);
      return $signed({64'd0, u});
   endfunction

   // expected result of one request
   function automatic vres_type vector_result(input logic [4:0] op, input q_type [2:0] a,
                                              input q_type [2:0] b, input q_type s);
      vres_type res;
      big_type  av[3], bv[3], r[3], sv, sc, m, lim, den, n;
      logic     ov, dz;
      bit       do_scale, use_s;
      ov = 1'b0;
      dz = 1'b0;
      sc = 0;
      do_scale = 1'b0;
      use_s = 1'b0;
      den = 0;
      lim = 0;
      sv = big_type'(s);
      for (int i = 0; i < 3; i++) begin
         av[i] = big_type'(a[i]);
         bv[i] = big_type'(b[i]);
         r[i]  = 0;
      end
      case (op)
         OP_ADDV: for (int i = 0; i < 3; i++) r[i] = av[i] + bv[i];
         OP_ADDS: for (int i = 0; i < 3; i++) r[i] = av[i] + sv;
         OP_SUBV: for (int i = 0; i < 3; i++) r[i] = av[i] - bv[i];
         OP_SUBS: for (int i = 0; i < 3; i++) r[i] = av[i] - sv;
         OP_MULV: for (int i = 0; i < 3; i++) r[i] = fmul(av[i], bv[i]);
         OP_MULS: for (int i = 0; i < 3; i++) r[i] = fmul(av[i], sv);
         OP_DIVV: for (int i = 0; i < 3; i++) r[i] = fdiv(av[i], bv[i], dz);
         OP_DIVS: for (int i = 0; i < 3; i++) r[i] = fdiv(av[i], sv, dz);
         OP_DOT: sc = clamp((av[0]*bv[0] + av[1]*bv[1] + av[2]*bv[2]) >>> FRAC, ov);
         OP_CROSS: begin
            r[0] = (av[1]*bv[2] - av[2]*bv[1]) >>> FRAC;
            r[1] = (av[2]*bv[0] - av[0]*bv[2]) >>> FRAC;
            r[2] = (av[0]*bv[1] - av[1]*bv[0]) >>> FRAC;
         end
         OP_MAG:   sc = clamp(widen(root64(squares(av[0], av[1], av[2]))), ov);
         OP_MAGSQ: sc = clamp(widen(squares(av[0], av[1], av[2]) >> FRAC), ov);
         OP_DIST:
            sc = clamp(widen(root64(squares(av[0]-bv[0], av[1]-bv[1], av[2]-bv[2]))), ov);
         OP_DISTSQ:
            sc = clamp(widen(squares(av[0]-bv[0], av[1]-bv[1], av[2]-bv[2]) >> FRAC), ov);
         OP_NORM, OP_NORMSAFE, OP_SETMAG, OP_SETMAGSAFE: begin
            do_scale = 1'b1;
            use_s = (op == OP_SETMAG) || (op == OP_SETMAGSAFE);
            lim = sv;
            den = widen(root64(squares(av[0], av[1], av[2])));
            if (op == OP_NORMSAFE || op == OP_SETMAGSAFE) den = den + EPS;
         end
         OP_LIMITS, OP_LIMITV: begin
            m = widen(root64(squares(av[0], av[1], av[2])));
            if (op == OP_LIMITS) begin
               lim = sv;
            end else begin
               lim = widen(root64(squares(bv[0], bv[1], bv[2])));
               if (lim > TOP) lim = TOP;
            end
            if (m > lim) begin
               do_scale = 1'b1;
               use_s = 1'b1;
               den = m + EPS;
            end else begin
               for (int i = 0; i < 3; i++) r[i] = av[i];
            end
         end
         OP_EQUAL: sc = (a == b) ? ONE : big_type'(0);
         default: ;
      endcase
      // normalise, then optionally scale by the target length
      if (do_scale) begin
         for (int i = 0; i < 3; i++) begin
            n = big_type'(clamp(fdiv(av[i], den, dz), ov));
            r[i] = use_s ? fmul(n, lim) : n;
         end
      end
      res.rx = clamp(r[0], ov);
      res.ry = clamp(r[1], ov);
      res.rz = clamp(r[2], ov);
      res.sc = q_type'(sc[31:0]);
      res.ov = ov;
      res.dz = dz;
      return res;
   endfunction

   // operand mix: full-range values, with small values, extremes and zero
   function automatic q_type pick_q();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return q_type'($urandom);
         4, 5: return q_type'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
         6: return q_type'($signed($urandom_range(0, 64)) - 32);
         7: return $urandom_range(0, 1) ? Q_MAX : Q_MIN;
         8: return q_type'($signed($urandom_range(0, 1 << 25)) - (1 << 24)) <<< 4;
         default: return '0;
      endcase
   endfunction

   // ---------------- request driver ----------------
   task automatic send_request(input logic [4:0] op, input q_type [2:0] a,
                               input q_type [2:0] b, input q_type s);
      int gap;
      gap = burst ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {s, b[2], b[1], b[0], a[2], a[1], a[0]};
      do @(posedge clock); while (!req_tready);
      expected_q.push_back(vector_result(op, a, b, s));
   endtask

   // ---------------- result side ----------------
   initial begin : result_ready
      int w;
      rsp_tready = 1'b0;
      forever begin
         w = burst ? 0 : $urandom_range(0, 19);
         if (w > 0) begin
            rsp_tready <= 1'b0;
            repeat (w) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // compare each result with the oldest prediction
   always @(posedge clock) begin
      vres_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata[31:0], rsp_tdata[63:32], rsp_tdata[95:64], rsp_tdata[127:96],
                rsp_tuser[0], rsp_tuser[1]};
         if (expected_q.size() == 0) begin
            n_mismatch++;
            if (n_mismatch <= 10) $display("unexpected result %h", got);
         end else begin
            want = expected_q.pop_front();
            if (got !== want) begin
               n_mismatch++;
               if (n_mismatch <= 10)
                  $display("mismatch: rx %h/%h ry %h/%h rz %h/%h sc %h/%h ov %b/%b dz %b/%b",
                           want.rx, got.rx, want.ry, got.ry, want.rz, got.rz,
                           want.sc, got.sc, want.ov, got.ov, want.dz, got.dz);
            end
         end
      end
   end

   // watchdog: too long with no handshake on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIM) begin
         $display("vector3_alu_tb failed");
         $finish;
      end
   end

   // ---------------- stimulus ----------------
   initial begin : stimulus
      vrow_type    rows[$];
      vrow_type    row;
      q_type [2:0] a, b;
      q_type       s;
      logic [4:0]  op;
      n_mismatch  = 0;
      idle_cycles = 0;
      burst       = 1'b0;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed table: typed results only where obvious
      rows.push_back('{OP_EQUAL, '0, '0, '0, 1, '{0, 0, 0, 32'sh0001_0000, 0, 0}});
      rows.push_back('{OP_ADDV, {Q_MAX, Q_MAX, Q_MAX}, {Q_MAX, Q_MIN, 32'sd1}, '0, 1,
                       '{Q_MAX, -32'sd1, Q_MAX, 0, 1, 0}});
      rows.push_back('{OP_DIVS, {32'sd0, -32'sd5, 32'sd5}, '0, '0, 1,
                       '{Q_MAX, Q_MIN, 0, 0, 0, 1}});
      rows.push_back('{OP_NORM, '0, '0, '0, 1, '{0, 0, 0, 0, 0, 1}});
      rows.push_back('{OP_NORMSAFE, '0, '0, '0, 1, '{0, 0, 0, 0, 0, 0}});
      rows.push_back('{OP_UNUSED, {Q_MAX, Q_MIN, 32'sd3}, {Q_MIN, 32'sd1, Q_MAX}, Q_MAX, 1,
                       '{0, 0, 0, 0, 0, 0}});
      rows.push_back('{5'd31, {Q_MIN, Q_MIN, Q_MIN}, {Q_MIN, Q_MIN, Q_MIN}, Q_MIN, 1,
                       '{0, 0, 0, 0, 0, 0}});
      for (int k = 0; k <= OP_EQUAL; k++) begin
         row.op = k[4:0];
         row.a  = {32'sh0003_0000, -32'sh0002_8000, 32'sh0001_0000};
         row.b  = {-32'sh0000_4000, 32'sh0005_0000, 32'sh0001_0000};
         row.s  = 32'sh0002_0000;
         row.typed = 1'b0;
         row.want = '0;
         rows.push_back(row);
      end
      rows.push_back('{OP_MAG, {Q_MIN, Q_MIN, Q_MIN}, '0, '0, 0, '0});
      rows.push_back('{OP_DISTSQ, {Q_MAX, Q_MAX, Q_MAX}, {Q_MIN, Q_MIN, Q_MIN}, '0, 0, '0});
      rows.push_back('{OP_DIST, {Q_MAX, Q_MAX, Q_MAX}, {Q_MIN, Q_MIN, Q_MIN}, '0, 0, '0});
      rows.push_back('{OP_LIMITV, {Q_MAX, Q_MIN, Q_MAX}, {Q_MIN, Q_MIN, Q_MIN}, '0, 0, '0});
      rows.push_back('{OP_SETMAG, '0, '0, Q_MIN, 0, '0});

      foreach (rows[i]) begin
         send_request(rows[i].op, rows[i].a, rows[i].b, rows[i].s);
         if (rows[i].typed) expected_q[$] = rows[i].want;
      end

      // hold off until the pipeline has drained
      req_tvalid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);

      // random part, with occasional back-to-back stretches
      for (int i = 0; i < N_RANDOM; i++) begin
         if ($urandom_range(0, 99) < 3) burst = ~burst;
         op = ($urandom_range(0, 19) == 0) ? 5'($urandom_range(21, 31))
                                           : 5'($urandom_range(0, 20));
         for (int j = 0; j < 3; j++) begin
            a[j] = pick_q();
            b[j] = ($urandom_range(0, 7) == 0) ? a[j] : pick_q();
         end
         s = pick_q();
         send_request(op, a, b, s);
      end
      req_tvalid <= 1'b0;
      burst = 1'b0;

      while (expected_q.size() != 0) @(posedge clock);
      repeat (120) @(posedge clock);
      if (n_mismatch == 0 && expected_q.size() == 0) begin
         $display("vector3_alu_tb passed");
      end else begin
         $display("vector3_alu_tb failed");
      end
      $finish;
   end

endmodule
